/* rtl/core/fsmrp_pkg.sv */
package fsmrp_pkg;

  localparam int unsigned StateW  = 3;
  localparam int unsigned MaskW   = 8;
  localparam int unsigned MaxRows = 8;

  typedef enum logic [2:0] {
    OP_STEP    = 3'd0,
    OP_CHANGE  = 3'd1,
    OP_GARBAGE = 3'd2,
    OP_PURGE   = 3'd3,
    OP_DELETE  = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_REACH
  } ctrl_state_e;

  // power-up transition rows, A..H = 0..7, {next on 0, next on 1}
  localparam logic [StateW-1:0] ResetNext [MaxRows][2] = '{
    '{3'd6, 3'd3}, '{3'd0, 3'd5}, '{3'd3, 3'd4}, '{3'd4, 3'd7},
    '{3'd1, 3'd0}, '{3'd5, 3'd2}, '{3'd7, 3'd1}, '{3'd5, 3'd6}
  };

  // entries that point past the last state come up as state A
  function automatic logic [StateW-1:0] reset_next(input int unsigned row,
                                                   input int unsigned sel,
                                                   input int unsigned lim);
    logic [StateW-1:0] v;
    v = ResetNext[row % MaxRows][sel % 2];
    if (32'(v) < lim) begin
      return v;
    end
    return '0;
  endfunction

endpackage

/* rtl/core/fsmrp_in_if.sv */
interface fsmrp_in_if
  import fsmrp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic              input_bit;
  logic [StateW-1:0] new_next;
  logic [StateW-1:0] target_state;

  modport source (output valid, opcode, input_bit, new_next, target_state, input ready);
  modport sink   (input valid, opcode, input_bit, new_next, target_state, output ready);
endinterface

/* rtl/core/fsmrp_out_if.sv */
interface fsmrp_out_if
  import fsmrp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [StateW-1:0] present_state;
  logic [MaskW-1:0]  state_mask;
  logic [StateW-1:0] row_next_zero;
  logic [StateW-1:0] row_next_one;
  logic              row_is_deleted;
  logic              accepted;

  modport source (output valid, present_state, state_mask, row_next_zero, row_next_one,
                  row_is_deleted, accepted, input ready);
  modport sink   (input valid, present_state, state_mask, row_next_zero, row_next_one,
                  row_is_deleted, accepted, output ready);
endinterface

/* rtl/core/fsmrp_reach.sv */
module fsmrp_reach
  import fsmrp_pkg::*;
#(
  parameter int unsigned NUM_ROWS = 8
) (
  input  logic [NUM_ROWS-1:0][1:0][StateW-1:0] next_i,
  input  logic [NUM_ROWS-1:0]                  reach_i,
  input  logic [NUM_ROWS-1:0]                  removed_i,
  output logic [NUM_ROWS-1:0]                  reach_o
);

  localparam int unsigned RowW = $clog2(NUM_ROWS);

  // one propagation round: every reached row adds its live successors
  always_comb begin
    logic [StateW-1:0] n;
    reach_o = reach_i;
    for (int unsigned i = 0; i < NUM_ROWS; i++) begin
      for (int unsigned b = 0; b < 2; b++) begin
        n = next_i[i][b];
        if (reach_i[i] && (32'(n) < NUM_ROWS) && !removed_i[n[RowW-1:0]]) begin
          reach_o[n[RowW-1:0]] = 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/programmable_fsm_with_reach_pruning_unit.sv */
// programmable state machine with reachability pruning
//
// in_i carries one command word (opcode, input bit, new next state, target
// state); out_o returns exactly one result word per command. A command is
// taken when in_i.valid and in_i.ready are high at a clock edge.
//
// step, change, delete one, read row and the unused opcodes finish in the
// accepting cycle: the result shows on out_o in the next cycle, one command
// every cycle while the receiver keeps up.
// garbage query and delete unreachable run the reachability unit, one
// propagation round per cycle, until the reached set stops growing or
// min(NUM_STATES, 8) rounds have run; the result then shows on out_o.
// in_i.ready is low while those rounds run.
//
// the output word sits in a register; a new command is taken only when
// that register is empty or drains in the same cycle, so a stalled receiver
// holds the command side after one word.
// reset (rst_ni low) loads the power-up transition table, puts the machine in state D
// (A if NUM_STATES < 4), clears the deleted set and empties the output register.
module programmable_fsm_with_reach_pruning_unit
  import fsmrp_pkg::*;
#(
  parameter int unsigned NUM_STATES = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  fsmrp_in_if.sink    in_i,
  fsmrp_out_if.source out_o
);

  localparam int unsigned NumRows = (NUM_STATES < MaxRows) ? NUM_STATES : MaxRows;
  localparam int unsigned RowW    = $clog2(NumRows);

  ctrl_state_e state_q, state_d;

  logic [NumRows-1:0][1:0][StateW-1:0] tbl_q;
  logic [StateW-1:0]  present_q;
  logic [NumRows-1:0] removed_q;
  logic [NumRows-1:0] reach_q;
  logic [RowW-1:0]    round_q;
  logic               purge_q;

  logic               out_valid_q;
  logic [StateW-1:0]  out_present_q;
  logic [MaskW-1:0]   out_mask_q;
  logic [StateW-1:0]  out_r0_q;
  logic [StateW-1:0]  out_r1_q;
  logic               out_rdel_q;
  logic               out_acc_q;

  logic               in_acc;
  logic               out_free;
  op_e                op;
  logic               is_reach_op;
  logic [StateW-1:0]  rd_idx;
  logic [1:0][StateW-1:0] rd_row;
  logic               tgt_ok;
  logic               tgt_removed;

  // immediate result and updates
  logic [StateW-1:0]  imm_present;
  logic [MaskW-1:0]   imm_mask;
  logic [StateW-1:0]  imm_r0;
  logic [StateW-1:0]  imm_r1;
  logic               imm_rdel;
  logic               imm_acc;
  logic               tbl_we;
  logic [NumRows-1:0] removed_set;

  logic [NumRows-1:0] reach_init;
  logic [NumRows-1:0] reach_next;
  logic               reach_done;
  logic [NumRows-1:0] garbage;
  logic [MaskW-1:0]   garbage_w;
  logic               finish;

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE) && out_free;
  assign in_acc      = in_i.valid && in_i.ready;
  assign op          = op_e'(in_i.opcode);
  assign is_reach_op = (op == OP_GARBAGE) || (op == OP_PURGE);

  // single row read port, shared by step (present) and read row (target)
  assign rd_idx      = (op == OP_READ) ? in_i.target_state : present_q;
  assign rd_row      = tbl_q[rd_idx[RowW-1:0]];
  assign tgt_ok      = 32'(in_i.target_state) < NumRows;
  assign tgt_removed = removed_q[in_i.target_state[RowW-1:0]];

  always_comb begin
    imm_present = present_q;
    imm_mask    = '0;
    imm_r0      = '0;
    imm_r1      = '0;
    imm_rdel    = 1'b0;
    imm_acc     = 1'b1;
    tbl_we      = 1'b0;
    removed_set = '0;
    unique case (op)
      OP_STEP: begin
        imm_present = rd_row[in_i.input_bit];
      end
      OP_CHANGE: begin
        tbl_we = 32'(in_i.new_next) < NUM_STATES;
      end
      OP_DELETE: begin
        if (tgt_ok && !tgt_removed) begin
          removed_set[in_i.target_state[RowW-1:0]] = 1'b1;
          imm_mask[in_i.target_state]              = 1'b1;
        end else begin
          imm_acc = 1'b0;
        end
      end
      OP_READ: begin
        if (tgt_ok) begin
          imm_r0   = rd_row[0];
          imm_r1   = rd_row[1];
          imm_rdel = tgt_removed;
        end
      end
      default: begin
      end
    endcase
  end

  // seed of the search: the present state unless it is deleted
  always_comb begin
    reach_init = '0;
    reach_init[present_q[RowW-1:0]] = !removed_q[present_q[RowW-1:0]];
  end

  fsmrp_reach #(
    .NUM_ROWS (NumRows)
  ) u_reach (
    .next_i    (tbl_q),
    .reach_i   (reach_q),
    .removed_i (removed_q),
    .reach_o   (reach_next)
  );

  assign reach_done = (reach_next == reach_q) || (round_q == RowW'(NumRows - 1));
  assign garbage    = ~reach_next & ~removed_q;
  assign finish     = (state_q == ST_REACH) && reach_done;

  always_comb begin
    garbage_w = '0;
    garbage_w[NumRows-1:0] = garbage;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc && is_reach_op) state_d = ST_REACH;
      ST_REACH: if (reach_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // machine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NumRows; i++) begin
        for (int unsigned b = 0; b < 2; b++) begin
          tbl_q[i][b] <= reset_next(i, b, NUM_STATES);
        end
      end
      present_q <= StateW'((NUM_STATES > 3) ? 3 : 0);
      removed_q <= '0;
      reach_q   <= '0;
      round_q   <= '0;
      purge_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        present_q <= imm_present;
        removed_q <= removed_q | removed_set;
        if (tbl_we) begin
          tbl_q[present_q[RowW-1:0]][in_i.input_bit] <= in_i.new_next;
        end
        if (is_reach_op) begin
          reach_q <= reach_init;
          round_q <= '0;
          purge_q <= (op == OP_PURGE);
        end
      end else if (state_q == ST_REACH) begin
        reach_q <= reach_next;
        round_q <= round_q + 1'b1;
        if (reach_done && purge_q) begin
          removed_q <= removed_q | garbage;
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((in_acc && !is_reach_op) || finish) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !is_reach_op) begin
      out_present_q <= imm_present;
      out_mask_q    <= imm_mask;
      out_r0_q      <= imm_r0;
      out_r1_q      <= imm_r1;
      out_rdel_q    <= imm_rdel;
      out_acc_q     <= imm_acc;
    end else if (finish) begin
      out_present_q <= present_q;
      out_mask_q    <= garbage_w;
      out_r0_q      <= '0;
      out_r1_q      <= '0;
      out_rdel_q    <= 1'b0;
      out_acc_q     <= 1'b1;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.present_state  = out_present_q;
  assign out_o.state_mask     = out_mask_q;
  assign out_o.row_next_zero  = out_r0_q;
  assign out_o.row_next_one   = out_r1_q;
  assign out_o.row_is_deleted = out_rdel_q;
  assign out_o.accepted       = out_acc_q;

endmodule

/* rtl/core/fsmrp_checker.sv */
module fsmrp_checker
  import fsmrp_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic [2:0]       in_opcode_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [MaskW-1:0] out_state_mask_i,
  input logic             out_row_is_deleted_i,
  input logic             out_accepted_i
);

  // a stalled word holds its mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_state_mask_i))
    else $error("stalled output word changed");

  // commands that need no search answer in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i != OP_GARBAGE) && (in_opcode_i != OP_PURGE)
    |=> out_valid_i)
    else $error("immediate command gave no word in the next cycle");

  // a refused delete reports no state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_accepted_i |-> out_state_mask_i == '0)
    else $error("refused delete carries a mask");

  // a read of a deleted row carries no mask and is never refused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_row_is_deleted_i |-> (out_state_mask_i == '0) && out_accepted_i)
    else $error("row read word carries a mask");

endmodule

bind programmable_fsm_with_reach_pruning_unit fsmrp_checker u_fsmrp_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_i.valid),
  .in_ready_i           (in_i.ready),
  .in_opcode_i          (in_i.opcode),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_state_mask_i     (out_o.state_mask),
  .out_row_is_deleted_i (out_o.row_is_deleted),
  .out_accepted_i       (out_o.accepted)
);
